// ===== hw/rtl/kdl_pkg.sv =====
// Shared types and constants for the key debounce / long-press event queue.
// No dependencies.
package kdl_pkg;

	localparam int KEYS        = 8;
	localparam int KEY_W       = 3;
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = 4;
	localparam int TICK_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONGPRESS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PUSH_ON_REL = 3'd4;

	localparam logic [TICK_W-1:0] FILTER_RESET    = 16'd20;
	localparam logic [TICK_W-1:0] LONGPRESS_RESET = 16'd1000;

	typedef enum logic [5:0] {
		PH_IDLE     = 6'b000001,
		PH_PRESS    = 6'b000010,
		PH_HELD     = 6'b000100,
		PH_RELEASE  = 6'b001000,
		PH_LONG     = 6'b010000,
		PH_LONG_REL = 6'b100000
	} phase_t;

	// queue entry: key index in the low bits, long flag on top
	typedef struct packed {
		logic             is_long;
		logic [KEY_W-1:0] key;
	} event_t;

endpackage

// ===== hw/rtl/key_debounce_longpress_fifo_unit.sv =====
// Key debounce scanner with long-press detection and event queue.
// Depends on kdl_pkg.
//
// Usage:
//  s_* channel: one beat is either a tick (s_tuser = 0) carrying the pin
//  levels of all keys in s_tdata, or a pop request (s_tuser = 1).
//  m_* channel: exactly one result beat per input beat, in order. m_tuser is
//  1 when a pop returned an event; m_tdata carries key, long flag, the queue
//  fill after the item and a dropped flag for ticks that met a full queue.
//  cfg_* port: register writes, taken on any edge with cfg_wr_en high; the user
//  must write only while the block is idle, the block itself does not enforce it.
//  Pipeline: an accepted beat passes the stage-1 register, which takes the
//  event RAM read, and then the output register. One beat per cycle is
//  sustained while m_tready stays high. The stage-1 register lets one more
//  beat in while a result waits on m_tready; after that s_tready drops until
//  the output is taken.
//  Reset: config registers return to defaults, scanner idle, queue empty.
//  The event RAM is not cleared; only written entries are ever read.
module key_debounce_longpress_fifo_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [kdl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kdl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,  // [7:0] pin_levels
	input  logic                               s_tuser,  // [0] kind
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [2:0] event_key, [3] event_long, [7:4] queue_count, [8] event_dropped
	output logic [15:0]                        m_tdata,
	output logic                               m_tuser   // [0] event_valid
);

	localparam int KW = kdl_pkg::KEY_W;
	localparam int PW = kdl_pkg::PTR_W;
	localparam int CW = kdl_pkg::CNT_W;
	localparam int TW = kdl_pkg::TICK_W;

	// configuration
	logic [3:0]    key_count_q;
	logic [7:0]    active_high_q;
	logic [TW-1:0] filter_q;
	logic [TW-1:0] longpress_q;
	logic          push_on_rel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q   <= '0;
			active_high_q <= '0;
			filter_q      <= kdl_pkg::FILTER_RESET;
			longpress_q   <= kdl_pkg::LONGPRESS_RESET;
			push_on_rel_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				kdl_pkg::REG_KEY_COUNT:   key_count_q   <= cfg_data[3:0];
				kdl_pkg::REG_ACTIVE_HIGH: active_high_q <= cfg_data[7:0];
				kdl_pkg::REG_FILTER:      filter_q      <= cfg_data[TW-1:0];
				kdl_pkg::REG_LONGPRESS:   longpress_q   <= cfg_data[TW-1:0];
				kdl_pkg::REG_PUSH_ON_REL: push_on_rel_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// scanner and queue control state
	kdl_pkg::phase_t phase_q, phase_d;
	logic [KW-1:0]   held_key_q, held_key_d;
	logic [TW-1:0]   elapsed_q, elapsed_d;
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   held_cnt_q, held_cnt_d;

	// pipeline
	logic          valid_s1, evalid_s1, dropped_s1;
	logic [CW-1:0] qcount_s1;
	kdl_pkg::event_t rd_data_s1;
	logic          out_valid_q, out_evalid_q, out_long_q, out_dropped_q;
	logic [KW-1:0] out_key_q;
	logic [CW-1:0] out_qcount_q;

	logic out_free, s1_free, accept;
	assign out_free = !out_valid_q || m_tready;
	assign s1_free  = !valid_s1 || out_free;
	assign s_tready = s1_free;
	assign accept   = s_tvalid && s1_free;

	// next-state logic
	logic          is_pop, is_tick;
	logic          pop_ok, push_req, push_long, push_ok, dropped_d;
	logic          held_active;
	logic [TW-1:0] elapsed_inc;
	logic          scan_hit;
	logic [KW-1:0] scan_key;

	assign is_pop  = s_tuser;
	assign is_tick = !s_tuser;
	assign held_active = (s_tdata[held_key_q] == active_high_q[held_key_q]);
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TW'(1);

	always_comb begin
		scan_hit = 1'b0;
		scan_key = '0;
		for (int i = 0; i < kdl_pkg::KEYS; i++) begin
			if (4'(i) < key_count_q && s_tdata[i] == active_high_q[i]) begin
				scan_hit = 1'b1;
				scan_key = KW'(i);
			end
		end
	end

	always_comb begin
		phase_d    = phase_q;
		held_key_d = held_key_q;
		elapsed_d  = elapsed_q;
		push_req   = 1'b0;
		push_long  = 1'b0;
		case (phase_q)
			kdl_pkg::PH_PRESS: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= filter_q) begin
					if (held_active) begin
						push_req = !push_on_rel_q;
						phase_d  = kdl_pkg::PH_HELD;
					end else begin
						phase_d = kdl_pkg::PH_IDLE;
					end
				end
			end
			kdl_pkg::PH_HELD: begin
				elapsed_d = elapsed_inc;
				if (!held_active) begin
					elapsed_d = '0;
					phase_d   = kdl_pkg::PH_RELEASE;
				end else if (elapsed_inc >= longpress_q) begin
					push_req  = 1'b1;
					push_long = 1'b1;
					phase_d   = kdl_pkg::PH_LONG;
				end
			end
			kdl_pkg::PH_RELEASE: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= filter_q) begin
					push_req = !held_active && push_on_rel_q;
					phase_d  = kdl_pkg::PH_IDLE;
				end
			end
			kdl_pkg::PH_LONG: begin
				elapsed_d = elapsed_inc;
				if (!held_active) begin
					elapsed_d = '0;
					phase_d   = kdl_pkg::PH_LONG_REL;
				end
			end
			kdl_pkg::PH_LONG_REL: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= filter_q)
					phase_d = held_active ? kdl_pkg::PH_LONG : kdl_pkg::PH_IDLE;
			end
			default: begin
				phase_d = kdl_pkg::PH_IDLE;
				if (scan_hit) begin
					held_key_d = scan_key;
					elapsed_d  = '0;
					phase_d    = kdl_pkg::PH_PRESS;
				end
			end
		endcase
	end

	assign pop_ok    = is_pop && (held_cnt_q != '0);
	assign push_ok   = is_tick && push_req && (held_cnt_q < CW'(kdl_pkg::QUEUE_DEPTH - 1));
	assign dropped_d = is_tick && push_req && !push_ok;

	always_comb begin
		held_cnt_d = held_cnt_q;
		if (pop_ok)
			held_cnt_d = held_cnt_q - CW'(1);
		else if (push_ok)
			held_cnt_d = held_cnt_q + CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= kdl_pkg::PH_IDLE;
			held_key_q <= '0;
			elapsed_q  <= '0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			held_cnt_q <= '0;
		end else if (accept) begin
			if (is_tick) begin
				phase_q    <= phase_d;
				held_key_q <= held_key_d;
				elapsed_q  <= elapsed_d;
			end
			if (push_ok)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop_ok)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			held_cnt_q <= held_cnt_d;
		end
	end

	// event RAM: one write port, one registered read port. A push and a pop
	// never share a beat, and a write is visible to the next beat's read.
	kdl_pkg::event_t event_mem [kdl_pkg::QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (accept && push_ok)
			event_mem[wr_ptr_q] <= '{is_long: push_long, key: held_key_q};
	end

	always_ff @(posedge clk) begin
		if (accept && pop_ok)
			rd_data_s1 <= event_mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_free)
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			evalid_s1  <= pop_ok;
			dropped_s1 <= dropped_d;
			qcount_s1  <= held_cnt_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_evalid_q  <= evalid_s1;
			out_key_q     <= evalid_s1 ? rd_data_s1.key : '0;
			out_long_q    <= evalid_s1 && rd_data_s1.is_long;
			out_qcount_q  <= qcount_s1;
			out_dropped_q <= dropped_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_evalid_q;
	assign m_tdata  = {7'd0, out_dropped_q, out_qcount_q, out_long_q, out_key_q};

endmodule

// ===== verif/tb_key_debounce_longpress_fifo_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for key_debounce_longpress_fifo_unit: stream driver, result monitor
// and a beat-level scanner/queue predictor. Depends on kdl_pkg and the unit RTL.
module tb_key_debounce_longpress_fifo_unit;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 750;
	localparam int MAX_REPORTS = 60;

	typedef struct packed {
		logic       kind;
		logic [7:0] pins;
	} stim_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] key;
		logic       is_long;
		logic [3:0] count;
		logic       dropped;
	} key_event_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wr_en = 1'b0;
	logic [kdl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [kdl_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata = '0;
	logic                           s_tuser = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [15:0]                    m_tdata;
	logic                           m_tuser;

	key_debounce_longpress_fifo_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers
	logic [3:0]  reg_key_count;
	logic [7:0]  reg_active_high;
	logic [15:0] reg_filter;
	logic [15:0] reg_longpress;
	logic        reg_push_on_rel;

	// predictor copy of scanner and queue
	kdl_pkg::phase_t scan_phase;
	logic [2:0]      scan_key;
	logic [15:0]     scan_elapsed;
	kdl_pkg::event_t event_ram [kdl_pkg::QUEUE_DEPTH];
	logic [3:0]      ev_wr_ptr;
	logic [3:0]      ev_rd_ptr;
	logic [3:0]      ev_held;

	stim_t      pending_beats [$];
	key_event_t expected_events [$];
	stim_t      next_beat;
	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;
	int         pop_pct = 0;
	int         beats_queued = 0;
	int         errors = 0;
	int         reports = 0;
	int         cycle_count = 0;
	bit         held_off = 1'b0;

	function automatic logic key_pressed(input logic [2:0] k, input logic [7:0] pins);
		return pins[k] == reg_active_high[k];
	endfunction

	// returns 1 when the event is lost to a full queue
	function automatic logic enqueue_event(input logic [2:0] k, input logic is_long);
		if (ev_held < 4'(kdl_pkg::QUEUE_DEPTH - 1)) begin
			event_ram[ev_wr_ptr] = '{is_long: is_long, key: k};
			ev_wr_ptr = ev_wr_ptr + 4'd1;
			ev_held = ev_held + 4'd1;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void bump_elapsed();
		if (scan_elapsed != 16'hFFFF)
			scan_elapsed = scan_elapsed + 16'd1;
	endfunction

	function automatic key_event_t scan_step(input logic kind, input logic [7:0] pins);
		key_event_t r;
		int         n;
		r = '0;
		if (kind) begin
			if (ev_held != 4'd0) begin
				r.valid = 1'b1;
				r.key = event_ram[ev_rd_ptr].key;
				r.is_long = event_ram[ev_rd_ptr].is_long;
				ev_rd_ptr = ev_rd_ptr + 4'd1;
				ev_held = ev_held - 4'd1;
			end
		end else begin
			case (scan_phase)
				kdl_pkg::PH_PRESS: begin
					bump_elapsed();
					if (scan_elapsed >= reg_filter) begin
						if (key_pressed(scan_key, pins)) begin
							if (!reg_push_on_rel)
								r.dropped = enqueue_event(scan_key, 1'b0);
							scan_phase = kdl_pkg::PH_HELD;
						end else begin
							scan_phase = kdl_pkg::PH_IDLE;
						end
					end
				end
				kdl_pkg::PH_HELD: begin
					bump_elapsed();
					if (!key_pressed(scan_key, pins)) begin
						scan_elapsed = '0;
						scan_phase = kdl_pkg::PH_RELEASE;
					end else if (scan_elapsed >= reg_longpress) begin
						r.dropped = enqueue_event(scan_key, 1'b1);
						scan_phase = kdl_pkg::PH_LONG;
					end
				end
				kdl_pkg::PH_RELEASE: begin
					bump_elapsed();
					if (scan_elapsed >= reg_filter) begin
						if (!key_pressed(scan_key, pins) && reg_push_on_rel)
							r.dropped = enqueue_event(scan_key, 1'b0);
						scan_phase = kdl_pkg::PH_IDLE;
					end
				end
				kdl_pkg::PH_LONG: begin
					bump_elapsed();
					if (!key_pressed(scan_key, pins)) begin
						scan_elapsed = '0;
						scan_phase = kdl_pkg::PH_LONG_REL;
					end
				end
				kdl_pkg::PH_LONG_REL: begin
					bump_elapsed();
					if (scan_elapsed >= reg_filter)
						scan_phase = key_pressed(scan_key, pins) ?
							kdl_pkg::PH_LONG : kdl_pkg::PH_IDLE;
				end
				default: begin
					n = (reg_key_count > 4'd8) ? 8 : int'(reg_key_count);
					scan_phase = kdl_pkg::PH_IDLE;
					for (int i = 0; i < n; i++) begin
						if (key_pressed(3'(i), pins)) begin
							scan_key = 3'(i);
							scan_elapsed = '0;
							scan_phase = kdl_pkg::PH_PRESS;
						end
					end
				end
			endcase
		end
		r.count = ev_held;
		return r;
	endfunction

	// driver: stream beats out of pending_beats, predicting each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_events.push_back(scan_step(s_tuser, s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_beat = pending_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_beat.pins;
					s_tuser <= next_beat.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			errors++;
			if (reports < MAX_REPORTS) begin
				reports++;
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
			end
		end
	endtask

	// monitor: random backpressure, compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					errors++;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("%0t: unexpected result beat: expected none, got %h/%b",
							$time, m_tdata, m_tuser);
					end
				end else begin
					key_event_t e;
					e = expected_events.pop_front();
					report_field("event_valid", e.valid, m_tuser);
					report_field("event_key", e.key, m_tdata[2:0]);
					report_field("event_long", e.is_long, m_tdata[3]);
					report_field("queue_count", e.count, m_tdata[7:4]);
					report_field("event_dropped", e.dropped, m_tdata[8]);
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic push_beat(input logic kind, input logic [7:0] pins);
		pending_beats.push_back('{kind: kind, pins: pins});
		beats_queued++;
	endtask

	// tick with an occasional pop slipped in ahead of it
	task automatic push_tick(input logic [7:0] pins);
		if ($urandom_range(99) < pop_pct)
			push_beat(1'b1, 8'h00);
		push_beat(1'b0, pins);
	endtask

	task automatic wait_idle();
		while (pending_beats.size() != 0 || s_tvalid || expected_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [kdl_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			kdl_pkg::REG_KEY_COUNT:   reg_key_count = value[3:0];
			kdl_pkg::REG_ACTIVE_HIGH: reg_active_high = value[7:0];
			kdl_pkg::REG_FILTER:      reg_filter = value;
			kdl_pkg::REG_LONGPRESS:   reg_longpress = value;
			kdl_pkg::REG_PUSH_ON_REL: reg_push_on_rel = value[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(input logic [3:0] kc, input logic [7:0] mask,
			input logic [15:0] filt, input logic [15:0] lp, input logic por);
		wait_idle();
		write_reg(kdl_pkg::REG_KEY_COUNT, 16'(kc));
		write_reg(kdl_pkg::REG_ACTIVE_HIGH, 16'(mask));
		write_reg(kdl_pkg::REG_FILTER, filt);
		write_reg(kdl_pkg::REG_LONGPRESS, lp);
		write_reg(kdl_pkg::REG_PUSH_ON_REL, 16'(por));
	endtask

	// one press of a key with contact bounce on both edges and a quiet tail
	task automatic queue_keystroke();
		logic [7:0] rest;
		logic [7:0] act;
		int         n;
		int         k;
		int         hold;
		int         cap;
		n = (reg_key_count > 4'd8) ? 8 : int'(reg_key_count);
		rest = ~reg_active_high;
		for (int i = n; i < 8; i++)
			rest[i] = 1'($urandom_range(1));
		k = (n > 0) ? $urandom_range(n - 1) : $urandom_range(7);
		act = rest;
		act[k] = ~act[k];
		if (k > 0 && $urandom_range(9) == 0)
			act[$urandom_range(k - 1)] = ~rest[$urandom_range(k - 1)];
		cap = (reg_longpress < 40) ? int'(reg_longpress) : 40;
		hold = $urandom_range(cap + 4);
		repeat ($urandom_range(3)) push_tick($urandom_range(1) ? act : rest);
		for (int i = 0; i < hold; i++)
			push_tick(($urandom_range(19) == 0) ? rest : act);
		repeat ($urandom_range(3)) push_tick($urandom_range(1) ? act : rest);
		cap = (reg_filter < 6) ? int'(reg_filter) : 6;
		repeat ($urandom_range(1, cap + 3)) push_tick(rest);
	endtask

	initial begin
		int seg;
		int seg_end;
		int random_start;
		logic [3:0]  kc;
		logic [7:0]  mask;
		logic [15:0] filt;
		logic [15:0] lp;

		reg_key_count = 4'd0;
		reg_active_high = 8'h00;
		reg_filter = kdl_pkg::FILTER_RESET;
		reg_longpress = kdl_pkg::LONGPRESS_RESET;
		reg_push_on_rel = 1'b0;
		scan_phase = kdl_pkg::PH_IDLE;
		scan_key = '0;
		scan_elapsed = '0;
		ev_wr_ptr = '0;
		ev_rd_ptr = '0;
		ev_held = '0;
		for (int i = 0; i < kdl_pkg::QUEUE_DEPTH; i++)
			event_ram[i] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// defaults: nothing scanned, pop on an empty queue
		push_beat(1'b0, 8'h00);
		push_beat(1'b0, 8'hFF);
		push_beat(1'b1, 8'h00);

		// key count beyond range, all active low: key 7 wins, short then long
		configure(4'd15, 8'h00, 16'd1, 16'd3, 1'b0);
		repeat (4) push_beat(1'b0, 8'h00);
		repeat (2) push_beat(1'b0, 8'hFF);
		repeat (3) push_beat(1'b1, 8'hA5);

		// release mode, zero filter; key count drops below the held key mid-press
		configure(4'd8, 8'h40, 16'd0, 16'hFFFF, 1'b1);
		repeat (2) push_beat(1'b0, 8'h40);
		configure(4'd2, 8'h40, 16'd0, 16'hFFFF, 1'b1);
		repeat (2) push_beat(1'b0, 8'h00);
		push_beat(1'b1, 8'h00);

		random_start = beats_queued;
		seg = 0;
		while (beats_queued - random_start < RANDOM_ITEMS) begin
			case (seg % 6)
				0: begin
					kc = 4'd8; mask = 8'hFF; filt = 16'd0; lp = 16'd0;
				end
				1: begin
					kc = 4'd15; mask = 8'h00; filt = 16'hFFFF; lp = 16'hFFFF;
				end
				default: begin
					kc = ($urandom_range(9) < 7) ? 4'($urandom_range(1, 8))
						: 4'($urandom_range(15));
					mask = 8'($urandom);
					filt = 16'($urandom_range(4));
					lp = 16'($urandom_range(30));
				end
			endcase
			configure(kc, mask, filt, lp, (seg % 6 == 0) ? 1'b0 :
				(seg % 6 == 1) ? 1'b1 : 1'($urandom_range(1)));
			case (seg % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
				default: begin src_idle_pct = 32; sink_stall_pct = 32; end
			endcase
			case ($urandom_range(4))
				0: pop_pct = 0;
				1: pop_pct = 3;
				2: pop_pct = 10;
				3: pop_pct = 25;
				default: pop_pct = 50;
			endcase
			seg_end = beats_queued + 95;
			while (beats_queued < seg_end) begin
				if ($urandom_range(9) < 8) begin
					queue_keystroke();
				end else begin
					repeat ($urandom_range(1, 6))
						push_beat(1'($urandom_range(1)), 8'($urandom));
				end
				// hold the source off once until the pipe has fully drained
				if (seg == 2 && !held_off && beats_queued >= seg_end - 50) begin
					wait_idle();
					held_off = 1'b1;
				end
			end
			seg++;
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/kdl_pkg.sv
hw/rtl/key_debounce_longpress_fifo_unit.sv
verif/tb_key_debounce_longpress_fifo_unit.sv
